// ===== rtl/mtf_pkg.sv =====
// Shared constants, codes and types for the move-to-front position tracker.
package mtf_pkg;

  localparam int ITEM_W        = 8;
  localparam int POS_OUT_W     = 8;
  localparam int CNT_W         = 9;
  localparam int NUM_ITEMS_DEF = 256;
  localparam int STORE_DEPTH   = 256;

  localparam logic [CNT_W-1:0] ACTIVE_RESET = 9'd256;

  localparam logic ACT_MOVE   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  // Control broadcast from the sequencer to every slot cell.
  typedef struct packed {
    logic capture;
    logic shift;
  } mtf_ctl_t;

endpackage

// ===== rtl/move_to_front_position_tracker.sv =====
// Top level of the move-to-front position tracker: slot cell chain, sequencer, stores.
// A request is accepted with its match row captured, the find step encodes the row,
// and the move step shifts the list and registers the result; a new request can be
// taken in the cycle that result is strobed. Busy holds new requests off until then.
// Reset (rst, synchronous): list in identity order, all records cleared, active_count 256.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module move_to_front_position_tracker #(
  parameter int NUM_ITEMS = mtf_pkg::NUM_ITEMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [mtf_pkg::ITEM_W-1:0]    item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mtf_pkg::CNT_W-1:0]     cfg_data,
  output logic                          result_valid,
  output logic [mtf_pkg::ITEM_W-1:0]    item_echo,
  output logic [mtf_pkg::POS_OUT_W-1:0] position,
  output logic [mtf_pkg::POS_OUT_W-1:0] min_position,
  output logic [mtf_pkg::POS_OUT_W-1:0] max_position,
  output logic                          bad_item
);
  import mtf_pkg::*;

  // Widths of a slot's item id and of a slot number follow the list length.
  localparam int ID_W  = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int POS_W = ID_W;
  localparam int SA_W  = $clog2(STORE_DEPTH);

  // Sequencer: idle, find (encode the match row), move (shift and report).
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIND = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [CNT_W-1:0] active_count;

  // Request held for the whole transaction.
  logic              req_action;
  logic [ITEM_W-1:0] req_item;
  logic              req_bad;

  logic              accept;
  logic              in_bad;
  logic [ID_W+ITEM_W-1:0] in_wide;
  logic [ID_W+ITEM_W-1:0] req_wide;
  logic [ID_W-1:0]   in_key;
  logic [ID_W-1:0]   req_key;

  mtf_ctl_t          ctl;
  logic [ID_W-1:0]   slot_id [NUM_ITEMS];
  logic [NUM_ITEMS-1:0] hit;
  logic [POS_W-1:0]  pos;

  // Largest-position store: a memory with a registered read. Its entries are
  // only meaningful once the item has been moved; the moved flags double as
  // valid bits, so an unmoved item reads its own index.
  logic [POS_OUT_W-1:0]   ls_mem [STORE_DEPTH];
  logic [POS_OUT_W-1:0]   ls_rd;
  logic [STORE_DEPTH-1:0] moved;
  logic                   moved_rd;

  logic [POS_W+POS_OUT_W-1:0] pos_wide;
  logic [POS_OUT_W-1:0]   pos8;
  logic [POS_OUT_W-1:0]   largest;
  logic [POS_OUT_W-1:0]   hi;
  logic [POS_OUT_W-1:0]   lo;
  logic                   do_move;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Item numbers are compared against the active count and the list length in full width.
  assign in_bad   = ({1'b0, item} >= active_count) || (32'(item) >= NUM_ITEMS);
  assign in_wide  = {{ID_W{1'b0}}, item};
  assign in_key   = in_wide[ID_W-1:0];
  assign req_wide = {{ID_W{1'b0}}, req_item};
  assign req_key  = req_wide[ID_W-1:0];

  assign do_move     = (state == ST_MOVE) && !req_bad && (req_action == ACT_MOVE);
  assign ctl.capture = accept;
  assign ctl.shift   = do_move;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_FIND;
      end
      ST_FIND: begin
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_count <= ACTIVE_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        active_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_item   <= item;
      req_bad    <= in_bad;
    end
  end

  // The chain of slot cells. Slot zero is fed the moved item; every other
  // slot is fed by the slot ahead of it.
  for (genvar g = 0; g < NUM_ITEMS; g++) begin : g_slot
    logic [ID_W-1:0] prev_id;
    if (g == 0) begin : g_head
      assign prev_id = req_key;
    end else begin : g_body
      assign prev_id = slot_id[g-1];
    end
    mtf_cell #(
      .ID_W  (ID_W),
      .POS_W (POS_W),
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .key     (in_key),
      .prev_id (prev_id),
      .pos     (pos),
      .id      (slot_id[g]),
      .match   (hit[g])
    );
  end

  mtf_pos_enc #(
    .N     (NUM_ITEMS),
    .POS_W (POS_W)
  ) u_pos_enc (
    .clk  (clk),
    .load (state == ST_FIND),
    .hit  (hit),
    .pos  (pos)
  );

  // Store read happens with the request; the write of a move lands at the
  // end of the transaction, so a following read always sees it.
  always_ff @(posedge clk) begin
    if (accept) begin
      ls_rd <= ls_mem[SA_W'(item)];
    end
    if (do_move) begin
      ls_mem[SA_W'(req_item)] <= hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moved    <= '0;
      moved_rd <= 1'b0;
    end else begin
      if (accept) begin
        moved_rd <= moved[SA_W'(item)];
      end
      if (do_move) begin
        moved[SA_W'(req_item)] <= 1'b1;
      end
    end
  end

  // Reported positions are the low eight bits of the slot number.
  assign pos_wide = {{POS_OUT_W{1'b0}}, pos};
  assign pos8     = pos_wide[POS_OUT_W-1:0];
  assign largest  = moved_rd ? ls_rd : req_item;
  assign hi       = (pos8 > largest) ? pos8 : largest;
  assign lo       = ((req_action == ACT_MOVE) || moved_rd) ? '0 : req_item;

  // Result registers: one strobe per transaction, position fields cleared for a
  // rejected item.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_MOVE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MOVE) begin
      item_echo    <= req_item;
      bad_item     <= req_bad;
      position     <= req_bad ? '0 : pos8;
      min_position <= req_bad ? '0 : lo;
      max_position <= req_bad ? '0 : hi;
    end
  end

  // A result only ever follows the move step of a transaction.
  a_result_after_move: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_MOVE)
    else $error("result strobe without a finished transaction");

  // A request is never taken while a result is still being worked out.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIND || state == ST_MOVE) |-> !accept)
    else $error("request accepted during a transaction");

  // For an accepted item the largest position covers the current one.
  a_max_covers_pos: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !bad_item) |-> max_position >= position)
    else $error("largest position below current position");

  // A rejected item reports all positions as zero.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_item) |-> (position == '0 && min_position == '0
                                    && max_position == '0))
    else $error("rejected item with nonzero positions");

endmodule

// ===== rtl/mtf_cell.sv =====
// One slot of the ordered list: holds an item id, matches it and shifts it back.
module mtf_cell #(
  parameter int ID_W  = 8,
  parameter int POS_W = 8,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mtf_pkg::mtf_ctl_t    ctl,
  input  logic [ID_W-1:0]      key,
  input  logic [ID_W-1:0]      prev_id,
  input  logic [POS_W-1:0]     pos,
  output logic [ID_W-1:0]      id,
  output logic                 match
);
  import mtf_pkg::*;

  // Every slot at or ahead of the found position takes its neighbor's id;
  // slot zero's neighbor is the moved item itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      id    <= ID_W'(INDEX);
      match <= 1'b0;
    end else begin
      if (ctl.shift && (pos >= POS_W'(INDEX))) begin
        id <= prev_id;
      end
      if (ctl.capture) begin
        match <= (id == key);
      end
    end
  end

endmodule

// ===== rtl/mtf_pos_enc.sv =====
// Turns the one-hot match row of the slot cells into a registered slot number.
module mtf_pos_enc #(
  parameter int N     = 256,
  parameter int POS_W = 8
) (
  input  logic             clk,
  input  logic             load,
  input  logic [N-1:0]     hit,
  output logic [POS_W-1:0] pos
);
  import mtf_pkg::*;

  logic [POS_W-1:0] pos_next;

  // Exactly one slot matches, so an OR of the slot numbers gives its index.
  always_comb begin
    pos_next = '0;
    for (int s = 0; s < N; s++) begin
      if (hit[s]) begin
        pos_next = pos_next | POS_W'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos <= pos_next;
    end
  end

endmodule

// ===== sim/tb_move_to_front_position_tracker.sv =====
// Self-checking testbench for the move-to-front position tracker: directed and random requests.
`timescale 1ns / 1ps

module tb_move_to_front_position_tracker;
  import mtf_pkg::*;

  localparam int NUM_ITEMS = NUM_ITEMS_DEF;
  // Cycles with no accepted transaction of any kind before the run is declared hung.
  // The longest correct quiet stretch, a sender gap or a drain pause, is far
  // shorter, so this leaves a wide margin.
  localparam int HANG_LIMIT = 2000;

  // One expected result, field for field as the block presents it.
  typedef struct packed {
    logic [ITEM_W-1:0]    item_echo;
    logic [POS_OUT_W-1:0] position;
    logic [POS_OUT_W-1:0] min_position;
    logic [POS_OUT_W-1:0] max_position;
    logic                 bad_item;
  } placement_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 action;
  logic [ITEM_W-1:0]    item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data;
  logic                 result_valid;
  logic [ITEM_W-1:0]    item_echo;
  logic [POS_OUT_W-1:0] position;
  logic [POS_OUT_W-1:0] min_position;
  logic [POS_OUT_W-1:0] max_position;
  logic                 bad_item;

  // Our own copy of the tracker state: the list order, each item's largest
  // position record, whether it has ever been moved, and the active count.
  logic [ITEM_W-1:0] list_order [NUM_ITEMS];
  logic [ITEM_W-1:0] deepest_seen [NUM_ITEMS];
  logic              ever_moved [NUM_ITEMS];
  logic [CNT_W-1:0]  items_in_use;

  // Placements predicted for accepted requests whose results have not come yet.
  placement_t pending_placements [$];

  int mismatch_count = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  move_to_front_position_tracker #(
    .NUM_ITEMS(NUM_ITEMS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .item        (item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .item_echo   (item_echo),
    .position    (position),
    .min_position(min_position),
    .max_position(max_position),
    .bad_item    (bad_item)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Put the tracker copy into its reset state: identity order, each item's
  // record equal to its own index, nothing moved, all 256 items in use.
  function automatic void clear_tracker_copy();
    for (int i = 0; i < NUM_ITEMS; i++) begin
      list_order[i]   = ITEM_W'(i);
      deepest_seen[i] = ITEM_W'(i);
      ever_moved[i]   = 1'b0;
    end
    items_in_use = ACTIVE_RESET;
  endfunction

  // Append one prediction behind all the ones still waiting for a result.
  function automatic void enqueue_placement(input placement_t p);
    pending_placements.insert(pending_placements.size(), p);
  endfunction

  // Work out the placement for one request and apply its effect on the list.
  function automatic placement_t place_item(input logic act, input logic [ITEM_W-1:0] who);
    placement_t p;
    int slot;
    p = '0;
    p.item_echo = who;
    // An item outside the active range is flagged and leaves the state alone.
    if ({1'b0, who} >= items_in_use || int'(who) >= NUM_ITEMS) begin
      p.bad_item = 1'b1;
      return p;
    end
    slot = 0;
    for (int s = NUM_ITEMS - 1; s >= 0; s--) begin
      if (list_order[s] == who) slot = s;
    end
    p.position = POS_OUT_W'(slot);
    if (act == ACT_MOVE) begin
      // The record only rises; then the item goes to the front and everything
      // that stood ahead of it slides back one slot.
      if (ITEM_W'(slot) > deepest_seen[who]) deepest_seen[who] = ITEM_W'(slot);
      ever_moved[who] = 1'b1;
      for (int s = slot; s > 0; s--) list_order[s] = list_order[s - 1];
      list_order[0] = who;
      p.min_position = '0;
      p.max_position = deepest_seen[who];
    end else begin
      // A report folds in the current position without recording it.
      p.min_position = ever_moved[who] ? '0 : who;
      p.max_position = (ITEM_W'(slot) > deepest_seen[who]) ? ITEM_W'(slot) : deepest_seen[who];
    end
    return p;
  endfunction

  // Hold start low for the given pause (n >= 1 so start never toggles within one step).
  task automatic pause_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send one request. The sender works in bursts; at the start of each burst it
  // may sit idle for a random gap. Start stays high between back-to-back
  // requests, so only the fields change at the edge that accepts the previous one.
  task automatic send_request(input logic act, input logic [ITEM_W-1:0] who);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
    end
    burst_left--;
    start  <= 1'b1;
    action <= act;
    item   <= who;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge: predict now, before any result for it can appear.
    enqueue_placement(place_item(act, who));
  endtask

  // Let every outstanding result arrive, then keep waiting so the block
  // is truly idle before the configuration changes.
  task automatic drain_results();
    pause_sender(1);
    burst_left = 0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Change active_count through the configuration channel while idle.
  task automatic write_items_in_use(input logic [CNT_W-1:0] count);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    items_in_use = count;
    cfg_valid <= 1'b0;
  endtask

  // Random requests against the current active count. Most name an item in
  // range; the rest name any item and may be flagged. Only in-range requests
  // count toward the total.
  task automatic drive_random_requests(input int n);
    int in_range;
    int span;
    logic act;
    logic [ITEM_W-1:0] who;
    in_range = 0;
    span = (int'(items_in_use) > NUM_ITEMS) ? NUM_ITEMS : int'(items_in_use);
    while (in_range < n) begin
      act = $urandom_range(0, 1) ? ACT_REPORT : ACT_MOVE;
      if ($urandom_range(0, 9) == 0) who = ITEM_W'($urandom_range(0, 255));
      else who = ITEM_W'($urandom_range(0, span - 1));
      if (int'(who) < span) in_range++;
      send_request(act, who);
    end
  endtask

  // Edges of the full list: first and last items, moves from the very back,
  // a repeated move of the front item, and reports before and after moves.
  task automatic test_list_extremes();
    send_request(ACT_REPORT, 8'd0);
    send_request(ACT_REPORT, 8'd255);
    send_request(ACT_MOVE, 8'd255);
    send_request(ACT_REPORT, 8'd255);
    send_request(ACT_REPORT, 8'd0);
    send_request(ACT_MOVE, 8'd0);
    send_request(ACT_REPORT, 8'd254);
    send_request(ACT_MOVE, 8'd128);
    send_request(ACT_MOVE, 8'd128);
    send_request(ACT_REPORT, 8'd128);
    send_request(ACT_REPORT, 8'd127);
  endtask

  // Active count at its limits: one item, none at all, one short of the
  // list, and a value above the list size where only the list bounds apply.
  task automatic test_active_count_limits();
    write_items_in_use(9'd1);
    send_request(ACT_MOVE, 8'd0);
    send_request(ACT_REPORT, 8'd1);
    send_request(ACT_MOVE, 8'd255);
    write_items_in_use(9'd0);
    send_request(ACT_REPORT, 8'd0);
    send_request(ACT_MOVE, 8'd0);
    write_items_in_use(9'd255);
    send_request(ACT_MOVE, 8'd255);
    send_request(ACT_REPORT, 8'd254);
    write_items_in_use(9'd511);
    send_request(ACT_MOVE, 8'd200);
    send_request(ACT_REPORT, 8'd255);
  endtask

  task automatic test_random_full_list();
    write_items_in_use(ACTIVE_RESET);
    drive_random_requests(600);
  endtask

  // A short list churns the same few items, so records and order get deep.
  task automatic test_random_short_list();
    write_items_in_use(CNT_W'($urandom_range(2, 16)));
    drive_random_requests(300);
    write_items_in_use(9'd1);
    drive_random_requests(50);
  endtask

  task automatic test_random_oversized_count();
    write_items_in_use(9'd511);
    drive_random_requests(300);
  endtask

  task automatic test_random_mixed_counts();
    write_items_in_use(CNT_W'($urandom_range(1, 256)));
    drive_random_requests(300);
    write_items_in_use(CNT_W'($urandom_range(257, 510)));
    drive_random_requests(250);
  endtask

  // Result checker: every strobed result must match the oldest prediction.
  always @(posedge clk) begin
    placement_t want;
    if (!rst && result_valid) begin
      if (pending_placements.size() == 0) begin
        $error("result for item %0d arrived with no request outstanding", item_echo);
        mismatch_count++;
      end else begin
        want = pending_placements.pop_front();
        if (item_echo !== want.item_echo) begin
          $error("item_echo: expected %0d, got %0d", want.item_echo, item_echo);
          mismatch_count++;
        end
        if (position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position);
          mismatch_count++;
        end
        if (min_position !== want.min_position) begin
          $error("min_position: expected %0d, got %0d", want.min_position, min_position);
          mismatch_count++;
        end
        if (max_position !== want.max_position) begin
          $error("max_position: expected %0d, got %0d", want.max_position, max_position);
          mismatch_count++;
        end
        if (bad_item !== want.bad_item) begin
          $error("bad_item: expected %0b, got %0b", want.bad_item, bad_item);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any request, result or configuration transaction counts as
  // progress. A long stretch without one means the block has hung.
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", HANG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    action    <= ACT_MOVE;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    clear_tracker_copy();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_list_extremes();
    test_active_count_limits();
    test_random_full_list();
    test_random_short_list();
    test_random_oversized_count();
    test_random_mixed_counts();

    // All requests are in: wait for the last results, then a little longer in
    // case anything unexpected is still on its way.
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
